[hdl/qau_pkg.sv]
// ----------------------------------------------------------------------------
// qau_pkg: shared types and constants of the quaternion arithmetic unit
// Action codes, operand widths and the fixed-point default.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_W        = 64;
	// four full-precision terms at the smallest fraction width stay exact
	localparam int ACC_W         = 58;

	typedef enum logic [1:0] {
		ACT_MUL    = 2'd0,
		ACT_ROTATE = 2'd1,
		ACT_MATRIX = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef logic signed [DATA_W-1:0] word_t;

	function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		begin
			hi = ACC_W'(64'sd2147483647);
			lo = -ACC_W'(64'sd2147483648);
			if (v > hi) sat_word = word_t'(hi);
			else if (v < lo) sat_word = word_t'(lo);
			else sat_word = word_t'(v);
		end
	endfunction

endpackage

[hdl/quaternion_arith_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_arith_unit: Q-format quaternion multiply, rotate and matrix
// Streamed fixed-point Hamilton product, vector rotation and rotation matrix.
// ----------------------------------------------------------------------------
// channel   | dir | fields
// s_axis    | in  | tdata: action,left_w..z,right_w..z ; 
// m_axis    | out | tdata: elem_one..elem_four ; tlast: last
//
// Stages: s1 products of pass one, s2 sums, s3 products of pass two,
// s4 sums/saturate, s5 output row registers. One item per cycle for
// multiply and rotate while m_axis is ready; a matrix item occupies the
// output for four rows, and input stalls until its last row is taken.
// Reset clears all valid bits. A stall on m_axis holds every stage.
module quaternion_arith_unit
	import qau_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [1:0] action, [33:2] left_w, [65:34] left_x, [97:66] left_y,
	// [129:98] left_z, [161:130] right_w, [193:162] right_x,
	// [225:194] right_y, [257:226] right_z, [263:258] zero
	input  logic [263:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] elem_one, [63:32] elem_two, [95:64] elem_three, [127:96] elem_four
	output logic [127:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int CNT_W = 2;

	typedef logic signed [ACC_W-1:0] acc_t;

	// pipeline advance: whole pipe moves when the output stage can take data
	logic adv;
	logic out_busy;

	// ---------------- stage 0 decode
	action_t act_in;
	word_t   l_in [4];
	word_t   r_in [4];
	assign act_in = action_t'(s_axis_tdata[1:0]);
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			l_in[i] = word_t'(s_axis_tdata[2 + 32*i +: 32]);
			r_in[i] = word_t'(s_axis_tdata[130 + 32*i +: 32]);
		end
	end

	// ---------------- stage 1: sixteen products (or matrix doubled terms)
	logic          v_s1;
	action_t       act_s1;
	word_t         l_s1 [4];
	acc_t          p_s1 [16];

	function automatic acc_t fmul(input word_t a, input word_t b, input int sh);
		logic signed [PROD_W-1:0] p;
		begin
			p = PROD_W'(a) * PROD_W'(b);
			fmul = acc_t'(p >>> sh);
		end
	endfunction

	acc_t p_d [16];
	word_t q_op [4];
	always_comb begin
		for (int i = 0; i < 4; i++) q_op[i] = r_in[i];
		if (act_in == ACT_ROTATE) q_op[0] = '0;
		for (int i = 0; i < 16; i++) p_d[i] = '0;
		if (act_in == ACT_MATRIX) begin
			// xx yy zz xy xz yz wx wy wz
			p_d[0] = fmul(l_in[1], l_in[1], FRAC_BITS - 1);
			p_d[1] = fmul(l_in[2], l_in[2], FRAC_BITS - 1);
			p_d[2] = fmul(l_in[3], l_in[3], FRAC_BITS - 1);
			p_d[3] = fmul(l_in[1], l_in[2], FRAC_BITS - 1);
			p_d[4] = fmul(l_in[1], l_in[3], FRAC_BITS - 1);
			p_d[5] = fmul(l_in[2], l_in[3], FRAC_BITS - 1);
			p_d[6] = fmul(l_in[0], l_in[1], FRAC_BITS - 1);
			p_d[7] = fmul(l_in[0], l_in[2], FRAC_BITS - 1);
			p_d[8] = fmul(l_in[0], l_in[3], FRAC_BITS - 1);
		end else begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					p_d[4*i + j] = fmul(l_in[i], q_op[j], FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid && s_axis_tready && (act_in != ACT_NONE);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= act_in;
			l_s1   <= l_in;
			p_s1   <= p_d;
		end
	end

	// ---------------- stage 2: Hamilton sums, saturate; matrix rows formed
	logic    v_s2;
	action_t act_s2;
	word_t   l_s2 [4];
	word_t   t_s2 [4];
	word_t   m_s2 [9];

	function automatic acc_t pp(input acc_t p [16], input int a, input int b);
		pp = p[4*a + b];
	endfunction

	word_t t_d [4];
	word_t m_d [9];
	acc_t  one;
	always_comb begin
		one = acc_t'(1) <<< FRAC_BITS;
		t_d[0] = sat_word(pp(p_s1,0,0) - pp(p_s1,1,1) - pp(p_s1,2,2) - pp(p_s1,3,3));
		t_d[1] = sat_word(pp(p_s1,0,1) + pp(p_s1,1,0) + pp(p_s1,2,3) - pp(p_s1,3,2));
		t_d[2] = sat_word(pp(p_s1,0,2) - pp(p_s1,1,3) + pp(p_s1,2,0) + pp(p_s1,3,1));
		t_d[3] = sat_word(pp(p_s1,0,3) + pp(p_s1,1,2) - pp(p_s1,2,1) + pp(p_s1,3,0));
		// matrix: p_s1 holds xx yy zz xy xz yz wx wy wz in slots 0..8
		m_d[0] = sat_word(one - p_s1[1] - p_s1[2]);
		m_d[1] = sat_word(p_s1[3] + p_s1[8]);
		m_d[2] = sat_word(p_s1[4] - p_s1[7]);
		m_d[3] = sat_word(p_s1[3] - p_s1[8]);
		m_d[4] = sat_word(one - p_s1[0] - p_s1[2]);
		m_d[5] = sat_word(p_s1[5] + p_s1[6]);
		m_d[6] = sat_word(p_s1[4] + p_s1[7]);
		m_d[7] = sat_word(p_s1[5] - p_s1[6]);
		m_d[8] = sat_word(one - p_s1[0] - p_s1[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= act_s1;
			l_s2   <= l_s1;
			t_s2   <= t_d;
			m_s2   <= m_d;
		end
	end

	// ---------------- stage 3: products t * conj(l), conj negated at full width
	logic    v_s3;
	action_t act_s3;
	word_t   t_s3 [4];
	word_t   m_s3 [9];
	acc_t    p_s3 [16];

	function automatic acc_t cmul(input word_t a, input word_t b, input logic neg,
		input int sh);
		logic signed [PROD_W-1:0] p;
		begin
			p = PROD_W'(a) * PROD_W'(b);
			if (neg) p = -p;
			cmul = acc_t'(p >>> sh);
		end
	endfunction

	acc_t p3_d [16];
	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				p3_d[4*i + j] = cmul(t_s2[i], l_s2[j], j != 0, FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3 <= act_s2;
			t_s3   <= t_s2;
			m_s3   <= m_s2;
			p_s3   <= p3_d;
		end
	end

	// ---------------- stage 4: rotate sums and result select
	logic    v_s4;
	action_t act_s4;
	word_t   e_s4 [4];
	word_t   m_s4 [9];

	word_t e_d [4];
	always_comb begin
		e_d = t_s3;
		if (act_s3 == ACT_ROTATE) begin
			e_d[0] = sat_word(pp(p_s3,0,1) + pp(p_s3,1,0) + pp(p_s3,2,3) - pp(p_s3,3,2));
			e_d[1] = sat_word(pp(p_s3,0,2) - pp(p_s3,1,3) + pp(p_s3,2,0) + pp(p_s3,3,1));
			e_d[2] = sat_word(pp(p_s3,0,3) + pp(p_s3,1,2) - pp(p_s3,2,1) + pp(p_s3,3,0));
			e_d[3] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4 <= act_s3;
			e_s4   <= e_d;
			m_s4   <= m_s3;
		end
	end

	// ---------------- output stage: row sequencer for matrix results
	logic              out_v_q;
	logic              mat_q;
	logic [CNT_W-1:0]  row_q;
	word_t             m_q [9];
	word_t             e_q [4];
	logic              take;

	assign out_busy = out_v_q && !(m_axis_tready && (!mat_q || row_q == CNT_W'(3)));
	assign adv      = !out_busy;
	assign take     = adv && v_s4;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			mat_q   <= 1'b0;
			row_q   <= '0;
		end else if (adv) begin
			out_v_q <= v_s4;
			mat_q   <= v_s4 && (act_s4 == ACT_MATRIX);
			row_q   <= '0;
		end else if (m_axis_tready) begin
			row_q <= row_q + CNT_W'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (take) begin
			e_q <= e_s4;
			m_q <= m_s4;
		end
	end

	word_t o [4];
	always_comb begin
		o = e_q;
		if (mat_q) begin
			unique case (row_q)
				2'd0: o = '{m_q[0], m_q[1], m_q[2], word_t'(0)};
				2'd1: o = '{m_q[3], m_q[4], m_q[5], word_t'(0)};
				2'd2: o = '{m_q[6], m_q[7], m_q[8], word_t'(0)};
				default: o = '{word_t'(0), word_t'(0), word_t'(0),
					word_t'(DATA_W'(1) << FRAC_BITS)};
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {o[3], o[2], o[1], o[0]};
	assign m_axis_tlast  = !mat_q || row_q == CNT_W'(3);

	// a matrix row count advances only for matrix results
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !mat_q) |-> row_q == '0)
		else $error("row count moved on a single-row result");
	// input is refused exactly while the output holds an unfinished result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == !out_busy)
		else $error("ready mismatch");
	// a stalled output row stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(row_q) && m_axis_tvalid)
		else $error("row changed under stall");

endmodule
